// ===== design/ustc_pkg.sv =====
// ----------------------------------------------------------------------------
// ustc_pkg
// Widths, calendar constants and the month length function shared by the
// seconds-to-calendar block and its channel interfaces.
// ----------------------------------------------------------------------------
package ustc_pkg;

    localparam int EpochW  = 32;
    localparam int YearW   = 12;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int DaysW   = 16;   // whole days since the epoch, at most 49710

    localparam logic [EpochW-1:0] SecsPerDay    = 32'd86400;
    localparam logic [EpochW-1:0] SecsPerHour   = 32'd3600;
    localparam logic [EpochW-1:0] SecsPerMinute = 32'd60;

    localparam logic [YearW-1:0]  EpochYear  = 12'd1970;
    localparam logic [8:0]        DaysCommon = 9'd365;
    localparam logic [8:0]        DaysLeap   = 9'd366;

    // residues of the epoch year, stepped along with the year count
    localparam logic [1:0] EpochMod4   = 2'd2;
    localparam logic [6:0] EpochMod100 = 7'd70;
    localparam logic [8:0] EpochMod400 = 9'd370;
    localparam logic [6:0] LastMod100  = 7'd99;
    localparam logic [8:0] LastMod400  = 9'd399;

    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthApr = 4'd4;
    localparam logic [MonthW-1:0] MonthJun = 4'd6;
    localparam logic [MonthW-1:0] MonthSep = 4'd9;
    localparam logic [MonthW-1:0] MonthNov = 4'd11;

    function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] month,
                                                     input logic leap);
        logic [DayW-1:0] len;
        if (month == MonthFeb)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (month inside {MonthApr, MonthJun, MonthSep, MonthNov})
        begin
            len = 5'd30;
        end
        else
        begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

// ===== design/ustc_if.sv =====
// ----------------------------------------------------------------------------
// ustc channel interfaces
// Valid/ready channels for the timestamp input and the calendar result.
// ----------------------------------------------------------------------------
interface ustc_epoch_if import ustc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [EpochW-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);

endinterface

interface ustc_cal_if import ustc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [YearW-1:0]   year_out;
    logic [MonthW-1:0]  month_out;
    logic [DayW-1:0]    day_out;
    logic [HourW-1:0]   hour_out;
    logic [MinuteW-1:0] minute_out;
    logic [SecondW-1:0] second_out;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output hour_out, output minute_out, output second_out,
                    input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input hour_out, input minute_out, input second_out,
                    output ready);

endinterface

// ===== design/unix_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Converts seconds since 1970-01-01 00:00:00 UTC into the Gregorian date and
// time of day, using one shared subtract-and-compare unit under a sequencer.
//
//   channel     dir  payload                                         beats
//   timestamp   in   epoch_seconds[31:0]                             1
//   calendar    out  year_out, month_out, day_out, hour_out,
//                    minute_out, second_out                          1
//
// every step is one pass through the single 32-bit subtractor (16 day-division
// steps, 5 hour steps, 6 minute steps, one per year, one per month)
// timestamp.ready is high only while the sequencer is idle
// a finished result sits in the output register until taken; the next
// timestamp may be accepted meanwhile, its result waits for the register
// reset clears the sequencer and the output valid, nothing else
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar import ustc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    ustc_epoch_if.sink   timestamp,
    ustc_cal_if.source   calendar
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DAY   = 3'd1;
    localparam logic [2:0] S_HOUR  = 3'd2;
    localparam logic [2:0] S_MIN   = 3'd3;
    localparam logic [2:0] S_YEAR  = 3'd4;
    localparam logic [2:0] S_MONTH = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    logic [EpochW-1:0]  acc_reg, acc_next;
    logic [DaysW-1:0]   days_reg, days_next;
    logic [HourW-1:0]   hour_reg, hour_next;
    logic [MinuteW-1:0] minute_reg, minute_next;
    logic [SecondW-1:0] second_reg, second_next;
    logic [YearW-1:0]   year_reg, year_next;
    logic [MonthW-1:0]  month_reg, month_next;
    logic [DayW-1:0]    day_reg, day_next;
    logic [1:0]         mod4_reg, mod4_next;
    logic [6:0]         mod100_reg, mod100_next;
    logic [8:0]         mod400_reg, mod400_next;

    logic [YearW-1:0]   year_out_reg, year_out_next;
    logic [MonthW-1:0]  month_out_reg, month_out_next;
    logic [DayW-1:0]    day_out_reg, day_out_next;
    logic [HourW-1:0]   hour_out_reg, hour_out_next;
    logic [MinuteW-1:0] minute_out_reg, minute_out_next;
    logic [SecondW-1:0] second_out_reg, second_out_next;

    // shared unit
    logic [EpochW-1:0]  operand;
    logic [EpochW:0]    diff;
    logic               ge;
    logic [EpochW-1:0]  rem;
    logic               leap;

    assign leap = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));

    always_comb
    begin
        case (state_reg)
            S_DAY:   operand = SecsPerDay << cnt_reg;
            S_HOUR:  operand = SecsPerHour << cnt_reg;
            S_MIN:   operand = SecsPerMinute << cnt_reg;
            S_YEAR:  operand = {23'd0, (leap ? DaysLeap : DaysCommon)};
            S_MONTH: operand = {27'd0, month_length(month_reg, leap)};
            default: operand = '0;
        endcase
    end

    assign diff = {1'b0, acc_reg} - {1'b0, operand};
    assign ge   = ~diff[EpochW];
    assign rem  = ge ? diff[EpochW-1:0] : acc_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        days_next       = days_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        mod4_next       = mod4_reg;
        mod100_next     = mod100_reg;
        mod400_next     = mod400_reg;
        year_out_next   = year_out_reg;
        month_out_next  = month_out_reg;
        day_out_next    = day_out_reg;
        hour_out_next   = hour_out_reg;
        minute_out_next = minute_out_reg;
        second_out_next = second_out_reg;
        out_valid_next  = out_valid_reg & ~calendar.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (timestamp.valid)
                begin
                    acc_next   = timestamp.epoch_seconds;
                    cnt_next   = 4'd15;
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                acc_next  = rem;
                days_next = {days_reg[DaysW-2:0], ge};
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    cnt_next   = 4'd4;
                    state_next = S_HOUR;
                end
            end
            S_HOUR:
            begin
                acc_next  = rem;
                hour_next = {hour_reg[HourW-2:0], ge};
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    cnt_next   = 4'd5;
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                acc_next    = rem;
                minute_next = {minute_reg[MinuteW-2:0], ge};
                cnt_next    = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    // remainder is the second; switch the unit over to the day count
                    second_next = rem[SecondW-1:0];
                    acc_next    = {16'd0, days_reg};
                    year_next   = EpochYear;
                    mod4_next   = EpochMod4;
                    mod100_next = EpochMod100;
                    mod400_next = EpochMod400;
                    state_next  = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (ge)
                begin
                    acc_next    = diff[EpochW-1:0];
                    year_next   = year_reg + 12'd1;
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == LastMod100) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == LastMod400) ? 9'd0 : mod400_reg + 9'd1;
                end
                else
                begin
                    month_next = MonthJan;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (ge)
                begin
                    acc_next   = diff[EpochW-1:0];
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    day_next   = acc_reg[DayW-1:0] + 5'd1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || calendar.ready)
                begin
                    year_out_next   = year_reg;
                    month_out_next  = month_reg;
                    day_out_next    = day_reg;
                    hour_out_next   = hour_reg;
                    minute_out_next = minute_reg;
                    second_out_next = second_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        days_reg       <= days_next;
        hour_reg       <= hour_next;
        minute_reg     <= minute_next;
        second_reg     <= second_next;
        year_reg       <= year_next;
        month_reg      <= month_next;
        day_reg        <= day_next;
        mod4_reg       <= mod4_next;
        mod100_reg     <= mod100_next;
        mod400_reg     <= mod400_next;
        year_out_reg   <= year_out_next;
        month_out_reg  <= month_out_next;
        day_out_reg    <= day_out_next;
        hour_out_reg   <= hour_out_next;
        minute_out_reg <= minute_out_next;
        second_out_reg <= second_out_next;
    end

    assign timestamp.ready     = (state_reg == S_IDLE);
    assign calendar.valid      = out_valid_reg;
    assign calendar.year_out   = year_out_reg;
    assign calendar.month_out  = month_out_reg;
    assign calendar.day_out    = day_out_reg;
    assign calendar.hour_out   = hour_out_reg;
    assign calendar.minute_out = minute_out_reg;
    assign calendar.second_out = second_out_reg;

endmodule

// ===== tb/ustc_calendar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ustc_calendar_checker
// Watches the timestamp and calendar channels of the seconds-to-calendar
// block, predicts the date and time of every accepted timestamp and compares
// each accepted calendar transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module ustc_calendar_checker import ustc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    ustc_epoch_if timestamp,
    ustc_cal_if   calendar,
    output int    fail_count,
    output int    pending
);

    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } calendar_t;

    localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    calendar_t expected_dates [$];

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic calendar_t calendar_of(input logic [EpochW-1:0] secs);
        calendar_t   c;
        int unsigned days;
        int unsigned sod;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        days = secs / 86400;
        sod  = secs % 86400;
        yr   = 1970;
        mon  = 1;
        len  = leap_year(yr) ? 366 : 365;
        while (days >= len)
        begin
            days -= len;
            yr++;
            len = leap_year(yr) ? 366 : 365;
        end
        for (int m = 0; m < 12; m++)
        begin
            len = MonthLen[m];
            if (m == 1 && leap_year(yr))
            begin
                len = 29;
            end
            if (days < len)
            begin
                break;
            end
            days -= len;
            mon++;
        end
        c.year   = yr[YearW-1:0];
        c.month  = mon[MonthW-1:0];
        c.day    = DayW'(days + 1);
        c.hour   = HourW'(sod / 3600);
        c.minute = MinuteW'((sod % 3600) / 60);
        c.second = SecondW'(sod % 60);
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        calendar_t exp_c;
        if (rst_n)
        begin
            if (timestamp.valid && timestamp.ready)
            begin
                expected_dates.push_back(calendar_of(timestamp.epoch_seconds));
            end
            if (calendar.valid && calendar.ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: calendar transfer with nothing expected, got %0d-%0d-%0d",
                             $time, calendar.year_out, calendar.month_out, calendar.day_out);
                    fail_count++;
                end
                else
                begin
                    exp_c = expected_dates.pop_front();
                    check_field("year",   32'(exp_c.year),   32'(calendar.year_out));
                    check_field("month",  32'(exp_c.month),  32'(calendar.month_out));
                    check_field("day",    32'(exp_c.day),    32'(calendar.day_out));
                    check_field("hour",   32'(exp_c.hour),   32'(calendar.hour_out));
                    check_field("minute", 32'(exp_c.minute), 32'(calendar.minute_out));
                    check_field("second", 32'(exp_c.second), 32'(calendar.second_out));
                end
            end
            pending = expected_dates.size();
        end
    end

endmodule

// ===== tb/tb_unix_seconds_to_calendar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_calendar
// Drives timestamps into the seconds-to-calendar block: calendar edge cases
// first, then random timestamps with random idle and stall bursts on both
// channels. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_calendar import ustc_pkg::*; ;

    localparam int RandomCount = 1100;
    localparam int QuietFrom   = 950;   // no idling from here to the end
    localparam int DrainCycles = 200;

    logic clk;
    logic rst_n;
    bit   src_gaps;
    bit   sink_stalls;
    int   fail_count;
    int   pending;

    // epoch edges, day, year and leap edges, 2038 rollover, 2100 non-leap
    logic [EpochW-1:0] directed_times [20] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd31535999,   32'd31536000,   32'd68169600,   32'd94694399,
        32'd94694400,   32'd946684799,  32'd951782400,  32'd978220799,
        32'd2147483647, 32'd4107542399, 32'd4107542400, 32'hFFFF_FFFF
    };

    ustc_epoch_if ts_if ();
    ustc_cal_if   cal_if ();

    unix_seconds_to_calendar dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .timestamp (ts_if),
        .calendar  (cal_if)
    );

    ustc_calendar_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .timestamp  (ts_if),
        .calendar   (cal_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("unix_seconds_to_calendar: mismatch");
        $finish;
    end

    // half uniform random, most of the rest at or just before midnight, some near the top of the range
    function automatic logic [EpochW-1:0] random_timestamp();
        logic [EpochW-1:0] secs;
        int unsigned       pick;
        pick = $urandom_range(0, 7);
        if (pick < 4)
        begin
            secs = $urandom;
        end
        else if (pick < 7)
        begin
            secs = $urandom_range(0, 49709) * 86400;
            case ($urandom_range(0, 3))
                0: secs = secs + 86399;
                1: secs = secs + $urandom_range(0, 86399);
                default: ;
            endcase
        end
        else
        begin
            secs = $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
        end
        return secs;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_timestamp(input logic [EpochW-1:0] secs);
        if (src_gaps && $urandom_range(0, 2) == 0)
        begin
            ts_if.valid = 1'b0;
            ts_if.epoch_seconds = $urandom;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        ts_if.valid = 1'b1;
        ts_if.epoch_seconds = secs;
        do
        begin
            @(posedge clk);
        end
        while (!ts_if.ready);
        @(negedge clk);
    endtask

    // sink side: random stall bursts while enabled
    initial
    begin
        int stall_left;
        stall_left = 0;
        cal_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                cal_if.ready = 1'b0;
                stall_left--;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                cal_if.ready = 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
            begin
                cal_if.ready = 1'b1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        ts_if.valid = 1'b0;
        ts_if.epoch_seconds = '0;
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed_times[i])
        begin
            send_timestamp(directed_times[i]);
        end
        for (int n = 0; n < RandomCount; n++)
        begin
            if (n % 100 == 0)
            begin
                src_gaps = (n < QuietFrom) && ($urandom_range(0, 2) != 0);
                sink_stalls = (n < QuietFrom) && ($urandom_range(0, 2) != 0);
            end
            if (n == QuietFrom)
            begin
                src_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            send_timestamp(random_timestamp());
        end
        ts_if.valid = 1'b0;
        wait (pending == 0);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("unix_seconds_to_calendar: match");
        end
        else
        begin
            $display("unix_seconds_to_calendar: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ustc_pkg.sv
design/ustc_if.sv
design/unix_seconds_to_calendar.sv
tb/ustc_calendar_checker.sv
tb/tb_unix_seconds_to_calendar.sv
